// ----- design/dvn_pkg.sv -----
package dvn_pkg;

  localparam int COORD_W  = 32;
  localparam int MAG_W    = COORD_W + 1;
  localparam int SQ_W     = 2 * MAG_W;
  localparam int SUM_W    = SQ_W;
  localparam int LEN_W    = SUM_W / 2;
  localparam int SREM_W   = LEN_W + 3;
  localparam int UFRAC    = 30;
  localparam int UNIT_W   = UFRAC + 2;
  localparam int QW       = UFRAC + 1;
  localparam int DREM_W   = LEN_W + 1;
  localparam int SQ_CELLS = LEN_W;
  localparam int DV_CELLS = UFRAC;
  localparam int IN_W     = 6 * COORD_W;
  localparam int OUT_W    = ((3 * UNIT_W + LEN_W + 7) / 8) * 8;

  typedef struct packed {
    logic [2:0]            neg;
    logic [2:0][MAG_W-1:0] mag;
  } mag3_t;

  typedef struct packed {
    mag3_t              m;
    logic [SUM_W-1:0]   rad;
    logic [SREM_W-1:0]  rem;
    logic [LEN_W-1:0]   root;
  } sq_t;

  typedef struct packed {
    logic [2:0]             neg;
    logic [2:0][DREM_W-1:0] rem;
    logic [2:0][QW-1:0]     q;
    logic [LEN_W-1:0]       len;
  } dv_t;

endpackage

// ----- design/dvn_sqrt_cell.sv -----
module dvn_sqrt_cell import dvn_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic up_valid,
  output logic up_ready,
  input  sq_t  up_data,
  output logic dn_valid,
  input  logic dn_ready,
  output sq_t  dn_data
);

  logic              valid_r;
  sq_t               data_r;
  sq_t               data_nxt;
  logic [SREM_W-1:0] rs;
  logic [SREM_W-1:0] trial;
  logic              take;

  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    rs    = {up_data.rem[SREM_W-3:0], up_data.rad[SUM_W-1 -: 2]};
    trial = {1'b0, up_data.root, 2'b01};
    take  = rs >= trial;
    data_nxt      = up_data;
    data_nxt.rad  = {up_data.rad[SUM_W-3:0], 2'b00};
    data_nxt.rem  = take ? rs - trial : rs;
    data_nxt.root = {up_data.root[LEN_W-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

// ----- design/dvn_div_cell.sv -----
module dvn_div_cell import dvn_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic up_valid,
  output logic up_ready,
  input  dv_t  up_data,
  output logic dn_valid,
  input  logic dn_ready,
  output dv_t  dn_data
);

  logic              valid_r;
  dv_t               data_r;
  dv_t               data_nxt;
  logic [DREM_W-1:0] r2;
  logic [DREM_W-1:0] lenx;
  logic              ge;

  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    data_nxt = up_data;
    lenx     = {1'b0, up_data.len};
    r2       = '0;
    ge       = 1'b0;
    for (int k = 0; k < 3; k++) begin
      r2 = {up_data.rem[k][DREM_W-2:0], 1'b0};
      ge = r2 >= lenx;
      data_nxt.rem[k] = ge ? r2 - lenx : r2;
      data_nxt.q[k]   = {up_data.q[k][QW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

// ----- design/direction_vector_normalize_top.sv -----
// direction vector normalizer
// in_* channel: one transfer carries two points, from and to, each axis signed
// Q16.16; the block forms d = from - to, its length floor(sqrt(|d|^2)) in
// unsigned Q17.16 and the unit vector trunc(d / length) in signed Q1.30
// out_* channel: one transfer per input transfer, in the same order;
// out_tuser flags a zero length, in which case the unit vector is zero
// pipeline: three front stages for difference, squares and sum, 33
// square-root cells at one root bit each, one integer quotient stage, 30
// divider cells at one quotient bit each, one output stage
// throughput: one transfer per cycle unless the output stalls; every cell is a
// pipeline register with its own valid bit, so bubbles close up and in_tready
// stays high whenever out_tvalid is low or out_tready is high
// reset: rst_n low empties the pipeline; nothing else is kept
// stall: when out_tready is low the output holds and the chain fills up
// behind it, in_tready falls only once every cell holds an item
module direction_vector_normalize_top import dvn_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // from_x, from_y, from_z, to_x, to_y, to_z
  input  logic [IN_W-1:0]  in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // unit_x, unit_y, unit_z, span_length, zero pad
  output logic [OUT_W-1:0] out_tdata,
  // zero_span
  output logic             out_tuser
);

  // difference and magnitude stage
  logic  va_r, vb_r, vc_r, vd_r, ve_r;
  logic  rdy_a, rdy_b, rdy_c, rdy_d, rdy_e;
  mag3_t ma_r, ma_nxt;
  mag3_t mb_r;
  logic [2:0][SQ_W-1:0] sqb_r;
  logic [MAG_W-1:0] df;

  assign rdy_a     = !va_r || rdy_b;
  assign in_tready = rdy_a;

  always_comb begin
    ma_nxt = '0;
    df     = '0;
    for (int k = 0; k < 3; k++) begin
      df = {in_tdata[k*COORD_W + COORD_W-1], in_tdata[k*COORD_W +: COORD_W]}
         - {in_tdata[(k+3)*COORD_W + COORD_W-1], in_tdata[(k+3)*COORD_W +: COORD_W]};
      ma_nxt.neg[k] = df[MAG_W-1];
      ma_nxt.mag[k] = df[MAG_W-1] ? (~df + 1'b1) : df;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (rdy_a) begin
      va_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a && in_tvalid) begin
      ma_r <= ma_nxt;
    end
  end

  // square stage
  assign rdy_b = !vb_r || rdy_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (rdy_b) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_b && va_r) begin
      mb_r <= ma_r;
      for (int k = 0; k < 3; k++) begin
        sqb_r[k] <= SQ_W'(ma_r.mag[k]) * SQ_W'(ma_r.mag[k]);
      end
    end
  end

  // sum stage feeding the square-root chain
  logic sq_v   [0:SQ_CELLS];
  logic sq_rdy [0:SQ_CELLS];
  sq_t  sq_d   [0:SQ_CELLS];
  sq_t  sc_r;

  assign rdy_c = !vc_r || sq_rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else if (rdy_c) begin
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_c && vb_r) begin
      sc_r.m    <= mb_r;
      sc_r.rad  <= sqb_r[0] + sqb_r[1] + sqb_r[2];
      sc_r.rem  <= '0;
      sc_r.root <= '0;
    end
  end

  assign sq_v[0] = vc_r;
  assign sq_d[0] = sc_r;

  for (genvar i = 0; i < SQ_CELLS; i++) begin : g_sq
    dvn_sqrt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (sq_v[i]),
      .up_ready (sq_rdy[i]),
      .up_data  (sq_d[i]),
      .dn_valid (sq_v[i+1]),
      .dn_ready (sq_rdy[i+1]),
      .dn_data  (sq_d[i+1])
    );
  end

  // integer quotient stage
  logic dv_v   [0:DV_CELLS];
  logic dv_rdy [0:DV_CELLS];
  dv_t  dv_d   [0:DV_CELLS];
  dv_t  dd_r, dd_nxt;
  logic ge0;

  assign sq_rdy[SQ_CELLS] = rdy_d;
  assign rdy_d = !vd_r || dv_rdy[0];

  always_comb begin
    dd_nxt     = '0;
    dd_nxt.neg = sq_d[SQ_CELLS].m.neg;
    dd_nxt.len = sq_d[SQ_CELLS].root;
    ge0        = 1'b0;
    for (int k = 0; k < 3; k++) begin
      ge0 = sq_d[SQ_CELLS].m.mag[k] >= sq_d[SQ_CELLS].root;
      dd_nxt.rem[k] = DREM_W'(ge0 ? sq_d[SQ_CELLS].m.mag[k] - sq_d[SQ_CELLS].root
                                  : sq_d[SQ_CELLS].m.mag[k]);
      dd_nxt.q[k]   = QW'(ge0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= 1'b0;
    end else if (rdy_d) begin
      vd_r <= sq_v[SQ_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_d && sq_v[SQ_CELLS]) begin
      dd_r <= dd_nxt;
    end
  end

  assign dv_v[0] = vd_r;
  assign dv_d[0] = dd_r;

  for (genvar i = 0; i < DV_CELLS; i++) begin : g_dv
    dvn_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (dv_v[i]),
      .up_ready (dv_rdy[i]),
      .up_data  (dv_d[i]),
      .dn_valid (dv_v[i+1]),
      .dn_ready (dv_rdy[i+1]),
      .dn_data  (dv_d[i+1])
    );
  end

  // output stage
  logic [2:0][UNIT_W-1:0] unit_r, unit_nxt;
  logic [LEN_W-1:0]       len_r;
  logic                   zero_r;
  logic                   zl;
  logic [UNIT_W-1:0]      qx;

  assign dv_rdy[DV_CELLS] = rdy_e;
  assign rdy_e = !ve_r || out_tready;

  always_comb begin
    zl       = dv_d[DV_CELLS].len == '0;
    unit_nxt = '0;
    qx       = '0;
    for (int k = 0; k < 3; k++) begin
      qx = UNIT_W'(dv_d[DV_CELLS].q[k]);
      unit_nxt[k] = zl ? '0 : (dv_d[DV_CELLS].neg[k] ? (~qx + 1'b1) : qx);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ve_r <= 1'b0;
    end else if (rdy_e) begin
      ve_r <= dv_v[DV_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_e && dv_v[DV_CELLS]) begin
      unit_r <= unit_nxt;
      len_r  <= dv_d[DV_CELLS].len;
      zero_r <= zl;
    end
  end

  assign out_tvalid = ve_r;
  assign out_tuser  = zero_r;
  assign out_tdata  = {{(OUT_W - 3*UNIT_W - LEN_W){1'b0}}, len_r, unit_r[2], unit_r[1],
                       unit_r[0]};

  a_zero_unit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[3*UNIT_W-1:0] == '0)
    else $error("zero span with nonzero unit vector");

  a_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser == (out_tdata[3*UNIT_W +: LEN_W] == '0))
    else $error("zero span flag disagrees with length");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid || out_tready |-> in_tready)
    else $error("input stalled with free output");

endmodule
